// ===== rtl/ptcr_pkg.sv =====
// Package: field widths, command and register codes, mode and result types.
`timescale 1ns / 1ps
`default_nettype none

package ptcr_pkg;

    localparam int CMD_W      = 2;
    localparam int SAMPLE_W   = 10;
    localparam int THR_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    // Command codes carried by each tick
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RECORD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PLAY   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR  = 1'b1;

    localparam logic [THR_W-1:0] HIGH_THR_RESET = 10'd500;
    localparam logic [THR_W-1:0] LOW_THR_RESET  = 10'd200;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_REC  = 2'd1,
        MODE_PLAY = 2'd2
    } mode_t;

    typedef struct packed {
        logic tx_level;
        logic recording;
        logic playing;
        logic finished;
        logic rejected;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/ptcr_if.sv =====
// Interfaces: input tick channel and result channel, valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface ptcr_tick_if;
    import ptcr_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic                slot;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output cmd, output slot, output sample, input ready);
    modport sink   (input valid, input cmd, input slot, input sample, output ready);
endinterface

interface ptcr_result_if;
    logic valid;
    logic ready;
    logic tx_level;
    logic recording;
    logic playing;
    logic finished;
    logic rejected;

    modport source (output valid, output tx_level, output recording, output playing,
                    output finished, output rejected, input ready);
    modport sink   (input valid, input tx_level, input recording, input playing,
                    input finished, input rejected, output ready);
endinterface

`default_nettype wire

// ===== rtl/pulse_train_capture_replay.sv =====
// Top level: pulse train capture and replay around a duration memory.
// An accepted tick's result is registered in the output buffer.
// Throughput: one item per cycle while the skid stage is empty, served by the one read and
// one write port of the duration memory, one entry per tick; a two-deep output buffer
// takes one more tick while a result waits. Reset returns to idle, thresholds
// to 500 and 200; the memory is not cleared, a slot reads only once recorded.
`timescale 1ns / 1ps
`default_nettype none

module pulse_train_capture_replay #(
    parameter int ENTRIES       = 128,
    parameter int DURATION_BITS = 32
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_we,
    input  wire [ptcr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [ptcr_pkg::CFG_DATA_W-1:0]    cfg_data,
    ptcr_tick_if.sink                         tick,
    ptcr_result_if.source                     result
);
    import ptcr_pkg::*;

    // Index counts up to ENTRIES itself; address is {slot, entry}
    localparam int IDX_W     = $clog2(ENTRIES + 1);
    localparam int ENT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ADDR_W    = ENT_W + 1;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [THR_W-1:0] high_thr_reg;
    logic [THR_W-1:0] low_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_thr_reg <= HIGH_THR_RESET;
            low_thr_reg  <= LOW_THR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HIGH_THR: high_thr_reg <= cfg_data[THR_W-1:0];
                CFG_LOW_THR:  low_thr_reg  <= cfg_data[THR_W-1:0];
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output buffer: main register plus skid stage
    // ------------------------------------------------------------------
    logic    out_valid_reg;
    result_t out_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;
    logic    accept;
    logic    take;
    result_t res;

    // Ready depends only on the skid stage, so a tick is blocked only while the skid stage is full
    assign tick.ready = !skid_valid_reg;
    assign accept     = tick.valid && !skid_valid_reg;
    assign take       = out_valid_reg && result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || take)
            begin
                out_data_reg <= res;
            end
            else
            begin
                skid_data_reg <= res;
            end
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.tx_level  = out_data_reg.tx_level;
    assign result.recording = out_data_reg.recording;
    assign result.playing   = out_data_reg.playing;
    assign result.finished  = out_data_reg.finished;
    assign result.rejected  = out_data_reg.rejected;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    mode_t                    mode_reg,    mode_next;
    logic                     slot_reg,    slot_next;
    logic [IDX_W-1:0]         idx_reg,     idx_next;
    logic                     level_reg,   level_next;
    logic [DURATION_BITS-1:0] cnt_reg,     cnt_next;
    // A slot is marked once a recording into it starts. Playback cannot start
    // until that recording has filled every entry, so an unmarked slot plays
    // as all zero durations and a marked one holds only non-zero durations.
    logic [1:0]               written_reg, written_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            slot_reg    <= 1'b0;
            idx_reg     <= '0;
            level_reg   <= 1'b0;
            cnt_reg     <= '0;
            written_reg <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            slot_reg    <= slot_next;
            idx_reg     <= idx_next;
            level_reg   <= level_next;
            cnt_reg     <= cnt_next;
            written_reg <= written_next;
        end
    end

    // ------------------------------------------------------------------
    // Duration memory: one write and one registered read per cycle
    // ------------------------------------------------------------------
    logic [DURATION_BITS-1:0] dur_mem [MEM_DEPTH];
    logic [DURATION_BITS-1:0] dur_rd_reg;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [ADDR_W-1:0]        mem_raddr;
    logic [DURATION_BITS-1:0] cnt_inc;

    // Record writes the active entry; playback reads the entry it will time next cycle
    assign mem_waddr = {slot_reg, idx_reg[ENT_W-1:0]};
    assign mem_raddr = {slot_next, idx_next[ENT_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dur_mem[mem_waddr] <= cnt_inc;
        end
        dur_rd_reg <= dur_mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // Tick processing
    // ------------------------------------------------------------------
    logic             samp_level;
    logic             is_start;
    logic [IDX_W-1:0] idx_inc;

    // Hysteresis slicer: the high test wins when the thresholds overlap
    assign samp_level = (tick.sample > high_thr_reg) ? 1'b1 :
                        (tick.sample < low_thr_reg)  ? 1'b0 : level_reg;
    // Saturate the interval counter at its full width
    assign cnt_inc    = (cnt_reg == '1) ? cnt_reg : cnt_reg + DURATION_BITS'(1);
    assign idx_inc    = idx_reg + IDX_W'(1);
    assign is_start   = (tick.cmd == CMD_RECORD) || (tick.cmd == CMD_PLAY);

    always_comb
    begin
        mode_next    = mode_reg;
        slot_next    = slot_reg;
        idx_next     = idx_reg;
        level_next   = level_reg;
        cnt_next     = cnt_reg;
        written_next = written_reg;
        mem_we       = 1'b0;
        res          = '0;

        if (accept)
        begin
            if (is_start && (mode_reg != MODE_IDLE))
            begin
                res.rejected = 1'b1;
            end

            if (is_start && (mode_reg == MODE_IDLE))
            begin
                slot_next = tick.slot;
                idx_next  = '0;
                if (tick.cmd == CMD_RECORD)
                begin
                    // Arm only; sampling begins on the next tick
                    mode_next               = MODE_REC;
                    level_next              = 1'b0;
                    cnt_next                = '0;
                    written_next[tick.slot] = 1'b1;
                end
                else if (!written_reg[tick.slot])
                begin
                    // Empty slot: played as all zero durations, complete at once
                    cnt_next     = '0;
                    res.finished = 1'b1;
                end
                else
                begin
                    // First entry is non-zero, so the start tick drives low
                    mode_next = MODE_PLAY;
                    cnt_next  = DURATION_BITS'(1);
                end
            end
            else
            begin
                case (mode_reg)
                    MODE_REC:
                    begin
                        if (samp_level != level_reg)
                        begin
                            if (idx_reg >= IDX_W'(ENTRIES))
                            begin
                                // Change after the last entry ends the recording
                                mode_next    = MODE_IDLE;
                                cnt_next     = cnt_inc;
                                res.finished = 1'b1;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                idx_next   = idx_inc;
                                cnt_next   = '0;
                                level_next = samp_level;
                            end
                        end
                        else
                        begin
                            cnt_next = cnt_inc;
                        end
                    end
                    MODE_PLAY:
                    begin
                        if (cnt_reg >= dur_rd_reg)
                        begin
                            // Current entry spent: advance, the next one is non-zero
                            idx_next = idx_inc;
                            if (idx_inc == IDX_W'(ENTRIES))
                            begin
                                mode_next    = MODE_IDLE;
                                cnt_next     = '0;
                                res.finished = 1'b1;
                            end
                            else
                            begin
                                cnt_next     = DURATION_BITS'(1);
                                res.tx_level = idx_inc[0];
                            end
                        end
                        else
                        begin
                            cnt_next     = cnt_reg + DURATION_BITS'(1);
                            res.tx_level = idx_reg[0];
                        end
                    end
                    default: ;
                endcase
            end

            res.recording = (mode_next == MODE_REC);
            res.playing   = (mode_next == MODE_PLAY);
        end
    end

endmodule

`default_nettype wire
